### rtl/tlcrt_pkg.sv
// Shared types and constants for the two-level child route table.
// Used by tlcrt_cell and two_level_child_route_table; no dependencies.
package tlcrt_pkg;

	localparam int ID_W  = 8;
	localparam int CNT_W = 9;
	localparam int TOT_W = 17;

	localparam logic [1:0] OP_LOOKUP  = 2'd0;
	localparam logic [1:0] OP_MISSING = 2'd1;
	localparam logic [1:0] OP_AVAIL   = 2'd2;

	localparam logic [ID_W-1:0] NO_ROUTE = 8'd255;

	// Command token walking down the chain of child cells.
	typedef struct packed {
		logic             vld;
		logic [1:0]       op;
		logic [ID_W-1:0]  teller;
		logic [ID_W-1:0]  subject;
		logic             ok;        // subject id inside the table
		logic             self_hit;  // subject is itself a child
		logic             found;     // some lower child holds subject
		logic [ID_W-1:0]  grand;     // that child
		logic             removed;
		logic             inc;       // total += amt
		logic             dec;       // total -= amt
		logic [CNT_W-1:0] amt;
	} tok_t;

endpackage

### rtl/two_level_child_route_table.sv
// Top level of the two-level child route table: entry register, a chain of
// NODE_COUNT child cells, running total, output register with skid entry.
// Depends on tlcrt_pkg and tlcrt_cell.
//
//   channel | signals                                  | dir
//   in      | in_valid, in_ready, op, teller, subject  | to block
//   out     | out_valid, out_ready, direction, removed, | from block
//           | grandchild_total                          |
//
// Each item walks the cell chain one cell per cycle: it passes the entry
// register, every cell register and the output register, and the next item
// is taken only after the chain empties, so one item is in the chain at a time.
// Reset clears every present flag and the total at once; no clearing pass.
// A stalled result sits in the output register while the next item runs; a
// second waiting result parks in the skid entry and holds in_ready low.
module two_level_child_route_table #(
	parameter int NODE_COUNT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  teller,
	input  logic [7:0]  subject,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  direction,
	output logic        removed,
	output logic [16:0] grandchild_total
);
	localparam int TW = tlcrt_pkg::TOT_W;
	localparam int IW = tlcrt_pkg::ID_W;

	tlcrt_pkg::tok_t chain [0:NODE_COUNT];
	tlcrt_pkg::tok_t tok_in;
	tlcrt_pkg::tok_t tok_s0;
	tlcrt_pkg::tok_t ext;
	logic [NODE_COUNT:0] vld_vec;

	logic          busy_q;
	logic [TW-1:0] total_q;
	logic [TW-1:0] tot_n;
	logic [IW-1:0] dir_n;

	logic          out_vld_q;
	logic [IW-1:0] dir_q;
	logic          rem_q;
	logic [TW-1:0] tot_q;
	logic          skid_vld_q;
	logic [IW-1:0] skid_dir_q;
	logic          skid_rem_q;
	logic [TW-1:0] skid_tot_q;

	logic in_acc;
	logic out_free;

	assign in_ready = !busy_q && !skid_vld_q;
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_vld_q || out_ready;

	always_comb begin
		tok_in         = '0;
		tok_in.vld     = in_acc;
		tok_in.op      = op;
		tok_in.teller  = teller;
		tok_in.subject = subject;
		tok_in.ok      = (32'(subject) < NODE_COUNT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s0 <= '0;
		end else begin
			tok_s0 <= tok_in;
		end
	end

	assign chain[0] = tok_s0;

	genvar gi;
	generate
		for (gi = 0; gi < NODE_COUNT; gi++) begin : g_cell
			tlcrt_cell #(
				.NODE_COUNT(NODE_COUNT),
				.ID        (gi)
			) u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.tok_i (chain[gi]),
				.tok_s1(chain[gi+1])
			);
		end
		for (gi = 0; gi <= NODE_COUNT; gi++) begin : g_vld
			assign vld_vec[gi] = chain[gi].vld;
		end
	endgenerate

	assign ext = chain[NODE_COUNT];

	always_comb begin
		priority if (ext.inc)
			tot_n = total_q + TW'(ext.amt);
		else if (ext.dec)
			tot_n = total_q - TW'(ext.amt);
		else
			tot_n = total_q;
	end

	always_comb begin
		priority if (ext.op != tlcrt_pkg::OP_LOOKUP)
			dir_n = tlcrt_pkg::NO_ROUTE;
		else if (ext.self_hit)
			dir_n = ext.subject;
		else if (ext.found)
			dir_n = ext.grand;
		else
			dir_n = tlcrt_pkg::NO_ROUTE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			total_q    <= '0;
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
			dir_q      <= '0;
			rem_q      <= 1'b0;
			tot_q      <= '0;
			skid_dir_q <= '0;
			skid_rem_q <= 1'b0;
			skid_tot_q <= '0;
		end else begin
			if (in_acc)
				busy_q <= 1'b1;
			else if (ext.vld)
				busy_q <= 1'b0;
			if (ext.vld)
				total_q <= tot_n;
			if (out_free) begin
				out_vld_q <= skid_vld_q || ext.vld;
				if (skid_vld_q) begin
					dir_q      <= skid_dir_q;
					rem_q      <= skid_rem_q;
					tot_q      <= skid_tot_q;
					skid_vld_q <= 1'b0;
				end else if (ext.vld) begin
					dir_q <= dir_n;
					rem_q <= ext.removed;
					tot_q <= tot_n;
				end
			end else if (ext.vld) begin
				skid_vld_q <= 1'b1;
				skid_dir_q <= dir_n;
				skid_rem_q <= ext.removed;
				skid_tot_q <= tot_n;
			end
		end
	end

	assign out_valid        = out_vld_q;
	assign direction        = dir_q;
	assign removed          = rem_q;
	assign grandchild_total = tot_q;

	// at most one item in the chain
	assert property (@(posedge clk) disable iff (!arst_n) $countones(vld_vec) <= 1)
		else $error("more than one token in cell chain");

	// a finishing item always finds the skid entry free
	assert property (@(posedge clk) disable iff (!arst_n) ext.vld |-> !skid_vld_q && busy_q)
		else $error("result arrived with skid full or block idle");

	// a decrement never takes the total below zero
	assert property (@(posedge clk) disable iff (!arst_n)
		ext.vld && ext.dec |-> total_q >= TW'(ext.amt))
		else $error("grandchild total underflow");

	// an erased entry only comes from a non-lookup, which routes nowhere
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && removed |-> direction == tlcrt_pkg::NO_ROUTE)
		else $error("removed flag on a routed result");

endmodule

### rtl/tlcrt_cell.sv
// One child row: present flag, grandchild bitmap and its population count.
// Processes the token passing by and registers it for the next cell.
// Depends on tlcrt_pkg.
module tlcrt_cell #(
	parameter int NODE_COUNT = 256,
	parameter int ID         = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tlcrt_pkg::tok_t tok_i,
	output tlcrt_pkg::tok_t tok_s1
);
	localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int CW    = tlcrt_pkg::CNT_W;
	localparam int IW    = tlcrt_pkg::ID_W;
	localparam logic [IW-1:0] MY_ID = IW'(ID);

	logic                  present_q;
	logic [NODE_COUNT-1:0] row_q;
	logic [CW-1:0]         cnt_q;

	logic                  pres_n;
	logic [NODE_COUNT-1:0] row_n;
	logic [CW-1:0]         cnt_n;
	tlcrt_pkg::tok_t       tok_n;

	logic [IDX_W-1:0]      idx;
	logic [NODE_COUNT-1:0] bit_m;
	logic                  member;
	logic                  is_teller;
	logic                  self_ref;

	assign idx       = tok_i.subject[IDX_W-1:0];
	assign bit_m     = {{(NODE_COUNT-1){1'b0}}, 1'b1} << idx;
	assign member    = present_q && tok_i.ok && row_q[idx];
	assign is_teller = tok_i.vld && tok_i.ok && (tok_i.teller == MY_ID);
	assign self_ref  = (tok_i.teller == tok_i.subject);

	always_comb begin
		tok_n  = tok_i;
		pres_n = present_q;
		row_n  = row_q;
		cnt_n  = cnt_q;
		unique case (tok_i.op)
			tlcrt_pkg::OP_LOOKUP: begin
				if (tok_i.vld && tok_i.ok && tok_i.subject == MY_ID && present_q)
					tok_n.self_hit = 1'b1;
				if (tok_i.vld && member && !tok_i.found) begin
					tok_n.found = 1'b1;
					tok_n.grand = MY_ID;
				end
			end
			tlcrt_pkg::OP_MISSING: begin
				if (is_teller && present_q) begin
					if (self_ref) begin
						pres_n        = 1'b0;
						tok_n.removed = 1'b1;
						tok_n.dec     = 1'b1;
						tok_n.amt     = cnt_q;
					end else if (member) begin
						row_n         = row_q & ~bit_m;
						cnt_n         = cnt_q - CW'(1);
						tok_n.removed = 1'b1;
						tok_n.dec     = 1'b1;
						tok_n.amt     = CW'(1);
					end
				end
			end
			tlcrt_pkg::OP_AVAIL: begin
				if (is_teller) begin
					if (!present_q) begin
						// new child starts with an empty set, or holding the subject if not self
						pres_n    = 1'b1;
						row_n     = self_ref ? '0 : bit_m;
						cnt_n     = self_ref ? '0 : CW'(1);
						tok_n.inc = !self_ref;
						tok_n.amt = CW'(1);
					end else if (!self_ref && !row_q[idx]) begin
						row_n     = row_q | bit_m;
						cnt_n     = cnt_q + CW'(1);
						tok_n.inc = 1'b1;
						tok_n.amt = CW'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b0;
			tok_s1    <= '0;
		end else begin
			present_q <= pres_n;
			tok_s1    <= tok_n;
		end
	end

	// row and count are meaningful only while present
	always_ff @(posedge clk) begin
		row_q <= row_n;
		cnt_q <= cnt_n;
	end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Testbench for two_level_child_route_table: checks each result beat against
// a local copy of the child and grandchild tables. Depends on tlcrt_pkg and the RTL.
module tb;

	localparam int NODES = 256;
	localparam int ITEMS = 1050;
	localparam int IDLE_LIMIT = 6000;
	localparam int HOLD_CYCLES = 1500;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [tlcrt_pkg::ID_W-1:0]  direction;
		logic                        removed;
		logic [tlcrt_pkg::TOT_W-1:0] total;
	} route_reply_t;

	class route_checker;
		bit [NODES-1:0] is_child;
		bit [NODES-1:0] grand_sets [NODES];
		int unsigned    grand_total;
		route_reply_t   pending_routes [$];
		int             errors;

		function new();
			is_child = '0;
			foreach (grand_sets[i])
				grand_sets[i] = '0;
			grand_total = 0;
			errors = 0;
		endfunction

		function void note_request(logic [1:0] o, logic [7:0] t, logic [7:0] s);
			route_reply_t r;
			r.direction = tlcrt_pkg::NO_ROUTE;
			r.removed = 1'b0;
			case (o)
				tlcrt_pkg::OP_LOOKUP: begin
					if (s < NODES) begin
						if (is_child[s]) begin
							r.direction = s;
						end else begin
							for (int c = 0; c < NODES; c++) begin
								if (is_child[c] && grand_sets[c][s]) begin
									r.direction = c[7:0];
									break;
								end
							end
						end
					end
				end
				tlcrt_pkg::OP_MISSING: begin
					if (t < NODES && s < NODES && is_child[t]) begin
						if (t == s) begin
							grand_total -= $countones(grand_sets[t]);
							grand_sets[t] = '0;
							is_child[t] = 1'b0;
							r.removed = 1'b1;
						end else if (grand_sets[t][s]) begin
							grand_sets[t][s] = 1'b0;
							grand_total--;
							r.removed = 1'b1;
						end
					end
				end
				tlcrt_pkg::OP_AVAIL: begin
					if (t < NODES && s < NODES) begin
						is_child[t] = 1'b1;
						if (t != s && !grand_sets[t][s]) begin
							grand_sets[t][s] = 1'b1;
							grand_total++;
						end
					end
				end
				default: ;
			endcase
			r.total = grand_total[tlcrt_pkg::TOT_W-1:0];
			pending_routes.push_back(r);
		endfunction

		function void check_reply(logic [7:0] d, logic rm, logic [16:0] tot);
			route_reply_t e;
			if (pending_routes.size() == 0) begin
				$display("%0t: unexpected beat: expected none, actual dir %0d rm %0b total %0d",
					$time, d, rm, tot);
				errors++;
				return;
			end
			e = pending_routes.pop_front();
			if (d !== e.direction) begin
				$display("%0t: direction: expected %0d, actual %0d", $time, e.direction, d);
				errors++;
			end
			if (rm !== e.removed) begin
				$display("%0t: removed: expected %0b, actual %0b", $time, e.removed, rm);
				errors++;
			end
			if (tot !== e.total) begin
				$display("%0t: grandchild_total: expected %0d, actual %0d", $time, e.total, tot);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending_routes.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [7:0]  teller;
	logic [7:0]  subject;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  direction;
	logic        removed;
	logic [16:0] grandchild_total;

	route_checker checker_h = new();
	bit  calm;
	int  hold_cycles;
	int  idle_cycles;

	two_level_child_route_table #(.NODE_COUNT(NODES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.teller(teller),
		.subject(subject),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.direction(direction),
		.removed(removed),
		.grandchild_total(grandchild_total)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			checker_h.note_request(op, teller, subject);
		if (arst_n && out_valid && out_ready)
			checker_h.check_reply(direction, removed, grandchild_total);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	function automatic logic [7:0] pick_id();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return 8'($urandom_range(0, 11));
		else if (r < 7)
			return 8'($urandom_range(244, 255));
		else
			return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_beat(input logic [1:0] o, input logic [7:0] t, input logic [7:0] s);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		teller <= t;
		subject <= s;
		do @(posedge clk); while (in_ready !== 1'b1);
	endtask

	// result side: stall after a beat shows up, or keep ready high ahead of it
	initial begin
		int w;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			w = calm ? 0 : $urandom_range(0, 17);
			if (hold_cycles != 0) begin
				w = hold_cycles;
				hold_cycles = 0;
			end
			if (w != 0) begin
				out_ready <= 1'b0;
				do @(posedge clk); while (out_valid !== 1'b1);
				repeat (w) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	initial begin
		int r;
		logic [7:0] t;
		logic [7:0] s;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = tlcrt_pkg::OP_LOOKUP;
		teller = '0;
		subject = '0;
		calm = 1'b0;
		hold_cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		send_beat(tlcrt_pkg::OP_LOOKUP,  8'd0,   8'd0);
		send_beat(tlcrt_pkg::OP_MISSING, 8'd5,   8'd5);
		send_beat(tlcrt_pkg::OP_AVAIL,   8'd255, 8'd255);
		send_beat(tlcrt_pkg::OP_LOOKUP,  8'd17,  8'd255);
		send_beat(tlcrt_pkg::OP_AVAIL,   8'd0,   8'd0);
		send_beat(tlcrt_pkg::OP_AVAIL,   8'd0,   8'd255);
		send_beat(tlcrt_pkg::OP_AVAIL,   8'd0,   8'd7);
		send_beat(tlcrt_pkg::OP_AVAIL,   8'd3,   8'd7);
		send_beat(tlcrt_pkg::OP_LOOKUP,  8'd255, 8'd7);
		send_beat(tlcrt_pkg::OP_MISSING, 8'd0,   8'd7);
		send_beat(tlcrt_pkg::OP_LOOKUP,  8'd0,   8'd7);
		send_beat(tlcrt_pkg::OP_MISSING, 8'd0,   8'd7);
		send_beat(tlcrt_pkg::OP_AVAIL,   8'd0,   8'd0);
		send_beat(tlcrt_pkg::OP_LOOKUP,  8'd0,   8'd255);
		send_beat(tlcrt_pkg::OP_MISSING, 8'd3,   8'd3);
		send_beat(tlcrt_pkg::OP_LOOKUP,  8'd0,   8'd7);
		send_beat(OP_UNUSED,             8'd255, 8'd255);
		send_beat(OP_UNUSED,             8'd0,   8'd0);
		send_beat(tlcrt_pkg::OP_MISSING, 8'd255, 8'd255);
		send_beat(tlcrt_pkg::OP_LOOKUP,  8'd0,   8'd255);
		send_beat(tlcrt_pkg::OP_MISSING, 8'd0,   8'd0);
		send_beat(tlcrt_pkg::OP_MISSING, 8'd255, 8'd0);
		send_beat(tlcrt_pkg::OP_LOOKUP,  8'd255, 8'd0);

		for (int i = 23; i < ITEMS; i++) begin
			calm = ((i / 128) % 4) == 3;
			if (i == 400)
				hold_cycles = HOLD_CYCLES;
			t = pick_id();
			s = pick_id();
			r = $urandom_range(0, 19);
			if (r < 8)
				send_beat(tlcrt_pkg::OP_AVAIL, t, s);
			else if (r < 14)
				send_beat(tlcrt_pkg::OP_LOOKUP, t, s);
			else if (r < 18)
				send_beat(tlcrt_pkg::OP_MISSING, t, s);
			else if (r < 19)
				send_beat(OP_UNUSED, t, s);
			else
				send_beat(tlcrt_pkg::OP_MISSING, t, t);
		end
		in_valid <= 1'b0;
		calm = 1'b0;

		while (checker_h.outstanding() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (checker_h.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

### sim.f
rtl/tlcrt_pkg.sv
rtl/tlcrt_cell.sv
rtl/two_level_child_route_table.sv
test/tb.sv
